FILE: hw/rtl/olpf_pkg.sv
package olpf_pkg;

	localparam int OPCODE_SLOTS = 64;
	localparam int SLOT_W = (OPCODE_SLOTS > 1) ? $clog2(OPCODE_SLOTS) : 1;

	localparam int BYTE_W = 8;
	localparam int LEN_W = 11;
	localparam int CMD_W = 2;
	localparam int STAT_W = 2;
	localparam int IDXC_W = BYTE_W + 1;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = PADDR_W - 2;

	localparam logic [CMD_W-1:0] CMD_DATA = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TABLE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

	localparam logic [STAT_W-1:0] ST_DATA = 2'd0;
	localparam logic [STAT_W-1:0] ST_SKIP = 2'd1;
	localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd2;
	localparam logic [STAT_W-1:0] ST_BADPKT = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_QUIRK_EN = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_QUIRK_OP = 1'd1;

	localparam logic [BYTE_W-1:0] STRAY_LO = 8'h00;
	localparam logic [BYTE_W-1:0] STRAY_HI = 8'hFF;

	typedef struct packed {
		logic              wr_en;
		logic [BYTE_W-1:0] wr_idx;
		logic [LEN_W-1:0]  wr_len;
		logic              wr_hand;
		logic              rd_en;
		logic [BYTE_W-1:0] rd_idx;
	} tbl_req_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             hand;
	} tbl_rsp_t;

	typedef struct packed {
		logic              fix_en;
		logic [BYTE_W-1:0] opcode;
	} quirk_cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic [BYTE_W-1:0] packet_opcode;
		logic [LEN_W-1:0]  byte_offset;
		logic              first_of_packet;
		logic              last_of_packet;
		logic [STAT_W-1:0] status;
	} result_t;

	function automatic logic slot_ok(input logic [BYTE_W-1:0] idx);
		return {1'b0, idx} < IDXC_W'(OPCODE_SLOTS);
	endfunction

endpackage

FILE: hw/rtl/olpf_if.sv
interface olpf_in_if;
	import olpf_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [BYTE_W-1:0] byte_value;
	logic [BYTE_W-1:0] table_index;
	logic [LEN_W-1:0]  table_length;
	logic              table_handled;

	modport source(output valid, command, byte_value, table_index, table_length,
		table_handled, input ready);
	modport sink(input valid, command, byte_value, table_index, table_length,
		table_handled, output ready);
endinterface

interface olpf_out_if;
	import olpf_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic [BYTE_W-1:0] packet_opcode;
	logic [LEN_W-1:0]  byte_offset;
	logic              first_of_packet;
	logic              last_of_packet;
	logic [STAT_W-1:0] status;

	modport source(output valid, out_byte, packet_opcode, byte_offset, first_of_packet,
		last_of_packet, status, input ready);
	modport sink(input valid, out_byte, packet_opcode, byte_offset, first_of_packet,
		last_of_packet, status, output ready);
endinterface

FILE: hw/rtl/olpf_cfg.sv
module olpf_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [olpf_pkg::PADDR_W-1:0]  paddr,
	input  logic [olpf_pkg::PDATA_W-1:0]  pwdata,
	output logic [olpf_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output olpf_pkg::quirk_cfg_t          quirk
);
	import olpf_pkg::*;

	quirk_cfg_t            quirk_q;
	logic [REG_IDX_W-1:0]  reg_idx;
	logic                  wr_en;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en = psel & penable & pwrite;
	assign pready = 1'b1;
	assign quirk = quirk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quirk_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_QUIRK_EN: begin
					quirk_q.fix_en <= pwdata[0];
				end
				REG_QUIRK_OP: begin
					quirk_q.opcode <= pwdata[BYTE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_QUIRK_EN: prdata = PDATA_W'(quirk_q.fix_en);
			REG_QUIRK_OP: prdata = PDATA_W'(quirk_q.opcode);
			default:      prdata = '0;
		endcase
	end

endmodule

FILE: hw/rtl/olpf_table.sv
module olpf_table (
	input  logic               clk,
	input  logic               arst_n,
	input  olpf_pkg::tbl_req_t req,
	output olpf_pkg::tbl_rsp_t rsp
);
	import olpf_pkg::*;

	tbl_rsp_t                mem [OPCODE_SLOTS];
	logic [OPCODE_SLOTS-1:0] vld_q;
	tbl_rsp_t                rd_data_s1;
	logic                    rd_vld_s1;
	logic [SLOT_W-1:0]       wr_slot;
	logic [SLOT_W-1:0]       rd_slot;
	logic                    wr_ok;

	assign wr_slot = req.wr_idx[SLOT_W-1:0];
	assign rd_slot = req.rd_idx[SLOT_W-1:0];
	assign wr_ok = req.wr_en & slot_ok(req.wr_idx);

	// Entries never written read as zero through their valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_ok) begin
				vld_q[wr_slot] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_s1 <= vld_q[rd_slot];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[wr_slot] <= '{len: req.wr_len, hand: req.wr_hand};
		end
		if (req.rd_en) begin
			rd_data_s1 <= mem[rd_slot];
		end
	end

	assign rsp = rd_vld_s1 ? rd_data_s1 : '0;

endmodule

FILE: hw/rtl/olpf_core.sv
module olpf_core (
	input  logic                   clk,
	input  logic                   arst_n,
	olpf_in_if.sink                in_ch,
	olpf_out_if.source             out_ch,
	input  olpf_pkg::quirk_cfg_t   quirk,
	output olpf_pkg::tbl_req_t     tbl_req,
	input  olpf_pkg::tbl_rsp_t     tbl_rsp
);
	import olpf_pkg::*;

	logic              v_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [BYTE_W-1:0] byte_s1;

	logic [LEN_W-1:0]  left_q, left_n;
	logic [BYTE_W-1:0] cur_q, cur_n;
	logic [BYTE_W-1:0] prev_q, prev_n;
	logic [LEN_W-1:0]  off_q, off_n;
	logic              err_q, err_n;

	logic              out_v_q;
	result_t           out_res_q;
	result_t           res;
	logic              res_v;

	logic              adv;
	logic              accept;
	logic              fire;

	assign adv = !out_v_q || out_ch.ready;
	assign in_ch.ready = !v_s1 || adv;
	assign accept = in_ch.valid & in_ch.ready;
	assign fire = v_s1 & adv;

	// Table writes land at acceptance so a following byte already sees them.
	always_comb begin
		tbl_req.wr_en = accept && (in_ch.command == CMD_TABLE);
		tbl_req.wr_idx = in_ch.table_index;
		tbl_req.wr_len = in_ch.table_length;
		tbl_req.wr_hand = in_ch.table_handled;
		tbl_req.rd_en = accept;
		tbl_req.rd_idx = in_ch.byte_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= in_ch.command;
			byte_s1 <= in_ch.byte_value;
		end
	end

	always_comb begin
		left_n = left_q;
		cur_n = cur_q;
		prev_n = prev_q;
		off_n = off_q;
		err_n = err_q;
		res_v = 1'b0;
		res = '{out_byte: byte_s1, packet_opcode: byte_s1, byte_offset: '0,
			first_of_packet: 1'b1, last_of_packet: 1'b0, status: ST_DATA};
		case (cmd_s1)
			CMD_RESTART: begin
				err_n = 1'b0;
				left_n = '0;
				off_n = '0;
				cur_n = '0;
			end
			CMD_DATA: begin
				if (!err_q) begin
					res_v = 1'b1;
					if (left_q != '0) begin
						res.packet_opcode = cur_q;
						res.byte_offset = off_q;
						res.first_of_packet = 1'b0;
						res.last_of_packet = (left_q == LEN_W'(1));
						left_n = left_q - LEN_W'(1);
						off_n = off_q + LEN_W'(1);
					end else if (quirk.fix_en && (prev_q == quirk.opcode) &&
						((byte_s1 == STRAY_LO) || (byte_s1 == STRAY_HI))) begin
						res.packet_opcode = prev_q;
						res.first_of_packet = 1'b0;
						res.status = ST_SKIP;
					end else if (!slot_ok(byte_s1)) begin
						err_n = 1'b1;
						off_n = '0;
						res.status = ST_UNKNOWN;
					end else begin
						prev_n = byte_s1;
						if (!tbl_rsp.hand || (tbl_rsp.len == '0)) begin
							err_n = 1'b1;
							off_n = '0;
							res.status = ST_BADPKT;
						end else begin
							cur_n = byte_s1;
							left_n = tbl_rsp.len - LEN_W'(1);
							off_n = LEN_W'(1);
							res.last_of_packet = (tbl_rsp.len == LEN_W'(1));
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			cur_q <= '0;
			prev_q <= '0;
			off_q <= '0;
			err_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (fire) begin
				left_q <= left_n;
				cur_q <= cur_n;
				prev_q <= prev_n;
				off_q <= off_n;
				err_q <= err_n;
			end
			if (adv) begin
				out_v_q <= fire & res_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fire && res_v) begin
			out_res_q <= res;
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.out_byte = out_res_q.out_byte;
	assign out_ch.packet_opcode = out_res_q.packet_opcode;
	assign out_ch.byte_offset = out_res_q.byte_offset;
	assign out_ch.first_of_packet = out_res_q.first_of_packet;
	assign out_ch.last_of_packet = out_res_q.last_of_packet;
	assign out_ch.status = out_res_q.status;

	a_err_idle: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> (left_q == '0))
		else $error("Error latched with a packet still in progress.");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(({1'b0, off_q} + {1'b0, left_q}) <= (LEN_W + 1)'(2047)))
		else $error("Offset and remaining count exceed the packet length range.");

	a_cur_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(left_q != '0) |-> slot_ok(cur_q))
		else $error("Packet in progress with an opcode beyond the table.");

	a_skip_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && (out_res_q.status == ST_SKIP)) |->
		(!out_res_q.first_of_packet && !out_res_q.last_of_packet &&
		(out_res_q.byte_offset == '0)))
		else $error("Skipped byte carries packet marks.");

	a_no_stall_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_ch.ready) |-> !fire ##1 (out_v_q && $stable(out_res_q)))
		else $error("Stalled result changed or stage one advanced.");

endmodule

FILE: hw/rtl/opcode_length_packet_framer_top.sv
// Opcode/length packet framer.
// The input channel carries one command per transfer: a stream byte, a write of
// one opcode table entry, or a restart. The output channel carries one tagged
// byte per transfer for each stream byte that is not dropped; table writes and
// restarts give no output. Each opcode table entry holds a packet length and a
// handled flag; the first byte of a bad packet latches an error and is passed
// on with an error status, and later bytes are dropped until a restart.
// The block takes one transfer per cycle while the receiver does not stall.
// An accepted byte is registered with its table read in the input stage, and
// its result is loaded into the output register once that register is free.
// The table has one write and one registered read port, both used at
// acceptance.
// When the receiver stalls, the output register holds its result and one more
// item waits in the input stage; after that the input channel is not ready.
// Reset clears the framing state and the quirk registers, and every table entry
// reads as zero length and unhandled until written; no clearing pass is needed.
// The two quirk registers sit at byte addresses 0 and 4 of the APB port.
module opcode_length_packet_framer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	olpf_in_if.sink                       in_ch,
	olpf_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [olpf_pkg::PADDR_W-1:0]  paddr,
	input  logic [olpf_pkg::PDATA_W-1:0]  pwdata,
	output logic [olpf_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import olpf_pkg::*;

	quirk_cfg_t quirk;
	tbl_req_t   tbl_req;
	tbl_rsp_t   tbl_rsp;

	olpf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.quirk   (quirk)
	);

	olpf_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tbl_req),
		.rsp    (tbl_rsp)
	);

	olpf_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.quirk   (quirk),
		.tbl_req (tbl_req),
		.tbl_rsp (tbl_rsp)
	);

endmodule
